### hw/rtl/c3rlb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package c3rlb_pkg;

  localparam int DEF_HEIGHT  = 28;
  localparam int DEF_WIDTH   = 28;
  localparam int CW          = 5;   // coordinate width, holds padded positions up to 29
  localparam int PIX_W       = 8;
  localparam int FRAC        = 3;
  localparam int RES_W       = 7;
  localparam int NUM_FILTERS = 8;
  localparam int NUM_TAPS    = 9;
  localparam int NUM_WEIGHTS = NUM_FILTERS * NUM_TAPS;
  localparam int IDX_W       = 7;
  localparam int CMD_W       = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PIXEL  = 2'd0,
    CMD_WEIGHT = 2'd1,
    CMD_BIAS   = 2'd2
  } cmd_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CW-1:0] coord_t;
  typedef logic [NUM_TAPS-1:0][PIX_W-1:0] taps_t;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [PIX_W-1:0] pixel;
    logic [IDX_W-1:0]        load_index;
    logic signed [PIX_W-1:0] load_value;
  } item_t;

  typedef struct packed {
    logic [RES_W-1:0] filter0;
    logic [RES_W-1:0] filter1;
    logic [RES_W-1:0] filter2;
    logic [RES_W-1:0] filter3;
    logic [RES_W-1:0] filter4;
    logic [RES_W-1:0] filter5;
    logic [RES_W-1:0] filter6;
    logic [RES_W-1:0] filter7;
    coord_t           out_row;
    coord_t           out_col;
    logic             last_of_run;
    logic             end_of_frame;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_LEFT,
    S_PIX,
    S_RIGHT,
    S_BOTTOM
  } state_t;

  // One padded grid position handed from the sequencer to the datapath.
  typedef struct packed {
    logic   issue;
    logic   produce;
    logic   last;
    logic   eof;
    coord_t row;
    coord_t col;
    pix_t   pix;
  } visit_t;

  typedef struct packed {
    logic free;
    logic idle;
  } seq_status_t;

  // Result metadata travelling alongside the arithmetic stages.
  typedef struct packed {
    logic   produce;
    logic   last;
    logic   eof;
    coord_t row;
    coord_t col;
  } meta_t;

endpackage

`default_nettype wire

### hw/rtl/c3rlb_line_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One column slot of both line rows. The near row holds the previous grid row,
// the far row the one before it.
module c3rlb_line_cell
  import c3rlb_pkg::*;
(
  input  wire  clk,
  input  wire  en,
  input  pix_t near_in,
  input  pix_t far_in,
  output pix_t near_out,
  output pix_t far_out
);

  always_ff @(posedge clk) begin
    if (en) begin
      near_out <= near_in;
      far_out  <= far_in;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/c3rlb_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// One filter lane: nine registered products, then bias plus wrapped sum and ReLU.
module c3rlb_filter
  import c3rlb_pkg::*;
(
  input  wire              clk,
  input  wire              en,
  input  taps_t            win,
  input  taps_t            wts,
  input  pix_t             bias,
  output logic [RES_W-1:0] res
);

  logic signed [2*PIX_W-1:0] full [NUM_TAPS];
  pix_t                      prod [NUM_TAPS];
  pix_t                      sum;

  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      full[i] = $signed(win[i]) * $signed(wts[i]);
    end
  end

  // Floor to three fraction bits and keep the low byte.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        prod[i] <= full[i][FRAC+PIX_W-1:FRAC];
      end
    end
  end

  always_comb begin
    sum = bias;
    for (int i = 0; i < NUM_TAPS; i++) begin
      sum = sum + prod[i];
    end
    res = (!sum[PIX_W-1] && (sum != '0)) ? sum[RES_W-1:0] : '0;
  end

endmodule

`default_nettype wire

### hw/rtl/c3rlb_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Walks the padded grid: turns one pixel transaction into its run of positions.
module c3rlb_seq
  import c3rlb_pkg::*;
#(
  parameter int IMAGE_HEIGHT = DEF_HEIGHT,
  parameter int IMAGE_WIDTH  = DEF_WIDTH
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         adv,
  input  wire         take,
  input  pix_t        pixel,
  output visit_t      visit,
  output seq_status_t status
);

  localparam coord_t PW_LAST = coord_t'(IMAGE_WIDTH + 1);
  localparam coord_t W_LAST  = coord_t'(IMAGE_WIDTH - 1);
  localparam coord_t H_LAST  = coord_t'(IMAGE_HEIGHT - 1);
  localparam coord_t H_BOT   = coord_t'(IMAGE_HEIGHT + 1);
  localparam coord_t TWO     = coord_t'(2);

  state_t state, state_next;
  coord_t wcnt, wcnt_next;
  coord_t row_h;
  coord_t pix_col;
  pix_t   pix_q;
  logic   at_last_col;
  logic   at_last_row;
  coord_t frame_row;
  coord_t frame_col;

  coord_t vh;
  coord_t vw;
  pix_t   vpix;
  logic   final_pos;
  logic   issue;
  logic   produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wcnt      <= '0;
      frame_row <= '0;
      frame_col <= '0;
    end else begin
      state <= state_next;
      wcnt  <= wcnt_next;
      if (take) begin
        if (frame_col == W_LAST) begin
          frame_col <= '0;
          frame_row <= (frame_row == H_LAST) ? '0 : frame_row + coord_t'(1);
        end else begin
          frame_col <= frame_col + coord_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      row_h       <= frame_row + coord_t'(1);
      pix_col     <= frame_col + coord_t'(1);
      pix_q       <= pixel;
      at_last_col <= (frame_col == W_LAST);
      at_last_row <= (frame_row == H_LAST);
    end
  end

  always_comb begin
    state_next = state;
    wcnt_next  = wcnt;
    vh         = '0;
    vw         = '0;
    vpix       = '0;
    final_pos  = 1'b0;
    unique case (state)
      S_IDLE: begin
      end
      S_TOP: begin
        vw = wcnt;
        if (adv) begin
          if (wcnt == PW_LAST) begin
            state_next = S_LEFT;
            wcnt_next  = '0;
          end else begin
            wcnt_next = wcnt + coord_t'(1);
          end
        end
      end
      S_LEFT: begin
        vh = row_h;
        if (adv) begin
          state_next = S_PIX;
        end
      end
      S_PIX: begin
        vh        = row_h;
        vw        = pix_col;
        vpix      = pix_q;
        final_pos = !at_last_col;
        if (adv) begin
          state_next = at_last_col ? S_RIGHT : S_IDLE;
        end
      end
      S_RIGHT: begin
        vh        = row_h;
        vw        = PW_LAST;
        final_pos = !at_last_row;
        if (adv) begin
          state_next = at_last_row ? S_BOTTOM : S_IDLE;
          wcnt_next  = '0;
        end
      end
      S_BOTTOM: begin
        vh        = H_BOT;
        vw        = wcnt;
        final_pos = (wcnt == PW_LAST);
        if (adv) begin
          if (final_pos) begin
            state_next = S_IDLE;
          end else begin
            wcnt_next = wcnt + coord_t'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // A new pixel starts its run as soon as the previous run issues its last position.
    if (take) begin
      wcnt_next = '0;
      if (frame_col == '0) begin
        state_next = (frame_row == '0) ? S_TOP : S_LEFT;
      end else begin
        state_next = S_PIX;
      end
    end
  end

  assign issue   = (state != S_IDLE);
  assign produce = issue && (vh >= TWO) && (vw >= TWO);

  always_comb begin
    visit.issue   = issue;
    visit.produce = produce;
    visit.last    = produce && final_pos;
    visit.eof     = produce && (vh == H_BOT) && (vw == PW_LAST);
    visit.row     = vh - TWO;
    visit.col     = vw - TWO;
    visit.pix     = vpix;
    status.idle   = !issue;
    status.free   = !issue || (adv && final_pos);
  end

endmodule

`default_nettype wire

### hw/rtl/conv3x3_relu_line_buffer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                   Payload   Carries
// item      item_valid / item_ready     item      pixel, kernel weight or bias load
// result    result_valid / result_ready result    eight ReLU outputs and position
//
// The sequencer walks the zero-padded grid one position per cycle unless the output
// stalls: an interior pixel issues one position, a first or last column pixel two, the
// first pixel of a frame IMAGE_WIDTH+4 (top border row) and the last one IMAGE_WIDTH+4
// (bottom border row). A result passes the window, product and output registers in
// turn. A load transaction waits until no result is still being computed. Reset is
// synchronous and needs no clearing pass: the top border row rewrites the line rows
// before use. A stalled result holds the whole chain, window and arithmetic stages.
module conv3x3_relu_line_buffer
  import c3rlb_pkg::*;
#(
  parameter int IMAGE_HEIGHT = DEF_HEIGHT,
  parameter int IMAGE_WIDTH  = DEF_WIDTH
) (
  input  wire     clk,
  input  wire     rst,
  input  wire     item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  wire     result_ready,
  output result_t result
);

  // The line rows span the padded width, border columns included.
  localparam int PW = IMAGE_WIDTH + 2;

  logic        adv;
  logic        take;
  logic        accept;
  visit_t      visit;
  seq_status_t seq_status;
  logic        shift;

  pix_t        near_q [PW];
  pix_t        far_q  [PW];
  pix_t        win    [3][3];
  taps_t       win_taps;

  pix_t        kernel [NUM_WEIGHTS];
  pix_t        bias   [NUM_FILTERS];
  taps_t       fwt    [NUM_FILTERS];
  logic [RES_W-1:0] fres [NUM_FILTERS];

  meta_t       meta0;
  meta_t       meta1;
  result_t     result_q;

  // The whole datapath moves whenever the output register is free or being emptied.
  assign adv    = !result_valid || result_ready;
  assign accept = item_valid && item_ready;
  assign take   = accept && (item.command == CMD_PIXEL);
  assign shift  = adv && visit.issue;

  // Pixels follow one another back to back; loads must not disturb results in flight.
  assign item_ready = (item.command == CMD_PIXEL) ? seq_status.free
                    : (seq_status.idle && !meta0.produce && !meta1.produce);

  c3rlb_seq #(
    .IMAGE_HEIGHT(IMAGE_HEIGHT),
    .IMAGE_WIDTH (IMAGE_WIDTH)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .take  (take),
    .pixel (pix_t'(item.pixel)),
    .visit (visit),
    .status(seq_status)
  );

  // Chain of line cells. The near row takes the new position value, and the far
  // row takes whatever falls out of the near row one padded row later.
  for (genvar k = 0; k < PW; k++) begin : g_line
    if (k == 0) begin : g_head
      c3rlb_line_cell u_cell (
        .clk     (clk),
        .en      (shift),
        .near_in (visit.pix),
        .far_in  (near_q[PW-1]),
        .near_out(near_q[k]),
        .far_out (far_q[k])
      );
    end else begin : g_body
      c3rlb_line_cell u_cell (
        .clk     (clk),
        .en      (shift),
        .near_in (near_q[k-1]),
        .far_in  (far_q[k-1]),
        .near_out(near_q[k]),
        .far_out (far_q[k])
      );
    end
  end

  // The 3x3 window slides one column per position. Its stale contents never
  // reach an output because the first two columns of every row produce nothing.
  always_ff @(posedge clk) begin
    if (shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= far_q[PW-1];
      win[1][2] <= near_q[PW-1];
      win[2][2] <= visit.pix;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        win_taps[r*3+c] = win[r][c];
      end
    end
  end

  // Weight and bias stores. Out-of-range indexes and the unused command are ignored.
  always_ff @(posedge clk) begin
    if (accept && (item.command == CMD_WEIGHT) &&
        (item.load_index < IDX_W'(NUM_WEIGHTS))) begin
      kernel[item.load_index] <= pix_t'(item.load_value);
    end
    if (accept && (item.command == CMD_BIAS) &&
        (item.load_index < IDX_W'(NUM_FILTERS))) begin
      bias[item.load_index[$clog2(NUM_FILTERS)-1:0]] <= pix_t'(item.load_value);
    end
  end

  always_comb begin
    for (int f = 0; f < NUM_FILTERS; f++) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        fwt[f][i] = kernel[f*NUM_TAPS+i];
      end
    end
  end

  // Eight filter lanes share the window; each registers its products on adv.
  for (genvar f = 0; f < NUM_FILTERS; f++) begin : g_filter
    c3rlb_filter u_filter (
      .clk (clk),
      .en  (adv),
      .win (win_taps),
      .wts (fwt[f]),
      .bias(bias[f]),
      .res (fres[f])
    );
  end

  // meta0 lines up with the window, meta1 with the product registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      meta0        <= '0;
      meta1        <= '0;
      result_valid <= 1'b0;
    end else if (adv) begin
      meta0.produce <= shift && visit.produce;
      meta0.last    <= visit.last;
      meta0.eof     <= visit.eof;
      meta0.row     <= visit.row;
      meta0.col     <= visit.col;
      meta1         <= meta0;
      result_valid  <= meta1.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_q.filter0      <= fres[0];
      result_q.filter1      <= fres[1];
      result_q.filter2      <= fres[2];
      result_q.filter3      <= fres[3];
      result_q.filter4      <= fres[4];
      result_q.filter5      <= fres[5];
      result_q.filter6      <= fres[6];
      result_q.filter7      <= fres[7];
      result_q.out_row      <= meta1.row;
      result_q.out_col      <= meta1.col;
      result_q.last_of_run  <= meta1.last;
      result_q.end_of_frame <= meta1.eof;
    end
  end

  assign result = result_q;

  // A load never lands while a result that depends on the stores is still in flight.
  a_load_quiet : assert property (@(posedge clk) disable iff (rst)
    (accept && (item.command != CMD_PIXEL)) |-> (!meta0.produce && !meta1.produce))
    else $error("load transaction accepted with a result in flight");

  // The final output pixel is always the last result of its transaction.
  a_eof_last : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.end_of_frame) |-> result.last_of_run)
    else $error("end of frame without last of run");

  // Every result position lies inside the image.
  a_pos_range : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.out_row < CW'(IMAGE_HEIGHT)) &&
                      (result.out_col < CW'(IMAGE_WIDTH))))
    else $error("result position outside the image");

  // The chain only moves while the output side can take what it produces.
  a_hold_on_stall : assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> ($stable(meta0) && $stable(meta1)))
    else $error("pipeline advanced during an output stall");

endmodule

`default_nettype wire
